// ----- hw/rtl/assert_macros.svh -----
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked outside reset
`define DME_ASSERT_DIS(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("assertion failed");

// implication checked on every edge
`define DME_ASSERT_ALL(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/dme_pkg.sv -----
package dme_pkg;

    localparam int DATA_W       = 32;
    localparam int ANGLE_W      = 25;
    localparam int SQ_W         = 64;
    localparam int ROOT_W       = 32;
    localparam int REM_W        = 33;
    localparam int SQRT_STEPS   = 32;
    localparam int CORDIC_STEPS = 20;
    localparam int PRESCALE     = 24;
    localparam int FRAC_BITS    = 16;
    localparam int ANGLE_FRAC   = 32;
    localparam int RND_SH       = ANGLE_FRAC - FRAC_BITS;
    localparam int Z_W          = 42;
    localparam int XY_W         = 64;
    localparam int OPND_W       = 34;

    localparam int FRONT_LAT    = 2;
    localparam int SQRT_LAT     = SQRT_STEPS + 1;
    localparam int CORDIC_LAT   = CORDIC_STEPS + 2;
    localparam int MDLY_LAT     = FRONT_LAT + SQRT_LAT;
    localparam int TOTAL_LAT    = MDLY_LAT + CORDIC_LAT;

    localparam int S_TDATA_W    = 12 * DATA_W;
    localparam int M_FIELDS_W   = 6 * DATA_W + 3 * ANGLE_W;
    localparam int M_TDATA_W    = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic signed [Z_W-1:0] HALF_TURN     = 42'sd773094113280;
    localparam logic signed [63:0]    RAD_TO_DEG_Q32 = 64'sd246083499208;

    function automatic logic signed [Z_W-1:0] atan_step(input int i);
        logic signed [63:0] v;
        case (i)
            0:  v = 64'sd193273528320;
            1:  v = 64'sd114096026022;
            2:  v = 64'sd60285206653;
            3:  v = 64'sd30601712202;
            4:  v = 64'sd15360239180;
            5:  v = 64'sd7687607525;
            6:  v = 64'sd3844741810;
            7:  v = 64'sd1922488225;
            8:  v = 64'sd961258780;
            9:  v = 64'sd480631223;
            10: v = 64'sd240315841;
            11: v = 64'sd120157949;
            12: v = 64'sd60078978;
            13: v = 64'sd30039489;
            default: v = (RAD_TO_DEG_Q32 + (64'sd1 <<< (i - 1))) >>> i;
        endcase
        return v[Z_W-1:0];
    endfunction

endpackage

// ----- hw/rtl/dme_sqrt.sv -----
module dme_sqrt import dme_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [SQ_W-1:0]   n_in,
    output logic [ROOT_W-1:0] root_out
);

    logic [SQ_W-1:0]   n_reg   [SQRT_STEPS];
    logic [ROOT_W-1:0] q_reg   [SQRT_STEPS];
    logic [REM_W-1:0]  rem_reg [SQRT_STEPS];
    logic [ROOT_W-1:0] root_reg;
    logic [ROOT_W-1:0] root_next;

    for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_step
        logic [SQ_W-1:0]   n_prev;
        logic [ROOT_W-1:0] q_prev;
        logic [REM_W-1:0]  rem_prev;
        logic [REM_W+1:0]  remsh;
        logic [REM_W+1:0]  trial;
        logic [SQ_W-1:0]   n_next;
        logic [ROOT_W-1:0] q_next;
        logic [REM_W-1:0]  rem_next;

        if (s == 0) begin : g_first
            assign n_prev   = n_in;
            assign q_prev   = '0;
            assign rem_prev = '0;
        end else begin : g_rest
            assign n_prev   = n_reg[s-1];
            assign q_prev   = q_reg[s-1];
            assign rem_prev = rem_reg[s-1];
        end

        always_comb begin
            remsh  = {rem_prev, n_prev[SQ_W-1:SQ_W-2]};
            trial  = {1'b0, q_prev, 2'b01};
            n_next = {n_prev[SQ_W-3:0], 2'b00};
            if (remsh >= trial) begin
                rem_next = REM_W'(remsh - trial);
                q_next   = {q_prev[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next = remsh[REM_W-1:0];
                q_next   = {q_prev[ROOT_W-2:0], 1'b0};
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[s]   <= n_next;
                q_reg[s]   <= q_next;
                rem_reg[s] <= rem_next;
            end
        end
    end

    // round to nearest from the remainder
    assign root_next = q_reg[SQRT_STEPS-1]
                     + ROOT_W'(rem_reg[SQRT_STEPS-1] > {1'b0, q_reg[SQRT_STEPS-1]});

    always_ff @(posedge aclk) begin
        if (en) begin
            root_reg <= root_next;
        end
    end

    assign root_out = root_reg;

endmodule

// ----- hw/rtl/dme_cordic.sv -----
module dme_cordic import dme_pkg::*; (
    input  logic                      aclk,
    input  logic                      en,
    input  logic signed [OPND_W-1:0]  y_in,
    input  logic signed [OPND_W-1:0]  x_in,
    output logic signed [ANGLE_W-1:0] angle_out
);

    logic signed [XY_W-1:0]    x_reg    [CORDIC_STEPS+1];
    logic signed [XY_W-1:0]    y_reg    [CORDIC_STEPS+1];
    logic signed [Z_W-1:0]     z_reg    [CORDIC_STEPS+1];
    logic                      zero_reg [CORDIC_STEPS+1];
    logic signed [ANGLE_W-1:0] angle_reg;

    logic                      neg;
    logic signed [OPND_W-1:0]  xa;
    logic signed [OPND_W-1:0]  ya;
    logic signed [XY_W-1:0]    x0_next;
    logic signed [XY_W-1:0]    y0_next;
    logic signed [Z_W-1:0]     z0_next;
    logic signed [Z_W-1:0]     zr;
    logic signed [ANGLE_W-1:0] angle_next;

    // fold the left half plane and prescale
    always_comb begin
        neg     = x_in < 0;
        xa      = neg ? -x_in : x_in;
        ya      = neg ? -y_in : y_in;
        x0_next = {{(XY_W-OPND_W){xa[OPND_W-1]}}, xa} <<< PRESCALE;
        y0_next = {{(XY_W-OPND_W){ya[OPND_W-1]}}, ya} <<< PRESCALE;
        if (!neg) begin
            z0_next = '0;
        end else if (y_in >= 0) begin
            z0_next = HALF_TURN;
        end else begin
            z0_next = -HALF_TURN;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]    <= x0_next;
            y_reg[0]    <= y0_next;
            z_reg[0]    <= z0_next;
            zero_reg[0] <= (x_in == 0) && (y_in == 0);
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        localparam logic signed [Z_W-1:0] ATAN_I = atan_step(i);
        logic signed [XY_W-1:0] dx;
        logic signed [XY_W-1:0] dy;
        logic signed [XY_W-1:0] x_next;
        logic signed [XY_W-1:0] y_next;
        logic signed [Z_W-1:0]  z_next;

        always_comb begin
            dx = y_reg[i] >>> i;
            dy = x_reg[i] >>> i;
            if (y_reg[i] >= 0) begin
                x_next = x_reg[i] + dx;
                y_next = y_reg[i] - dy;
                z_next = z_reg[i] + ATAN_I;
            end else begin
                x_next = x_reg[i] - dx;
                y_next = y_reg[i] + dy;
                z_next = z_reg[i] - ATAN_I;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                x_reg[i+1]    <= x_next;
                y_reg[i+1]    <= y_next;
                z_reg[i+1]    <= z_next;
                zero_reg[i+1] <= zero_reg[i];
            end
        end
    end

    // round to nearest, ties up; a zero input vector gives angle zero
    always_comb begin
        zr = z_reg[CORDIC_STEPS] + (Z_W'(1) <<< (RND_SH - 1));
        if (zero_reg[CORDIC_STEPS]) begin
            angle_next = '0;
        end else begin
            angle_next = zr[RND_SH+ANGLE_W-1:RND_SH];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            angle_reg <= angle_next;
        end
    end

    assign angle_out = angle_reg;

endmodule

// ----- hw/rtl/decompose_matrix_euler_unit.sv -----
// pipeline from input transfer to result: square/sum, root and cordic stages
// throughput: one matrix per cycle while the output is not stalled, every unit is fully pipelined
// a stalled output freezes the whole pipeline; nothing is lost or repeated
// reset: aresetn synchronous active low clears only the stage valid bits
module decompose_matrix_euler_unit import dme_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // m11 m12 m13 m21 m22 m23 m31 m32 m33 m41 m42 m43, 32 bits each
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // scale_x scale_y scale_z (32), angle_x angle_y angle_z (25), pos_x pos_y pos_z (32)
    output logic [M_TDATA_W-1:0] m_tdata
);

    typedef struct packed {
        logic signed [DATA_W-1:0] m11;
        logic signed [DATA_W-1:0] m12;
        logic signed [DATA_W-1:0] m13;
        logic signed [DATA_W-1:0] m23;
        logic signed [DATA_W-1:0] m33;
        logic signed [DATA_W-1:0] m41;
        logic signed [DATA_W-1:0] m42;
        logic signed [DATA_W-1:0] m43;
    } side_t;

    typedef struct packed {
        logic [ROOT_W-1:0]        sx;
        logic [ROOT_W-1:0]        sy;
        logic [ROOT_W-1:0]        sz;
        logic signed [DATA_W-1:0] px;
        logic signed [DATA_W-1:0] py;
        logic signed [DATA_W-1:0] pz;
    } tail_t;

    logic                 en;
    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-1:0] vld_next;

    logic signed [DATA_W-1:0] m [12];
    logic [SQ_W-1:0]          sq_reg [9];
    logic [SQ_W-1:0]          sum_reg [4];
    logic [ROOT_W-1:0]        root [4];
    side_t                    side_in;
    side_t                    side_reg [MDLY_LAT];
    tail_t                    tail_in;
    tail_t                    tail_reg [CORDIC_LAT];
    logic signed [ANGLE_W-1:0] ang_x;
    logic signed [ANGLE_W-1:0] ang_y;
    logic signed [ANGLE_W-1:0] ang_z;
    logic signed [OPND_W-1:0] cy [3];
    logic signed [OPND_W-1:0] cx [3];

    assign en       = !vld_reg[TOTAL_LAT-1] || m_tready;
    assign s_tready = en && aresetn;
    assign vld_next = {vld_reg[TOTAL_LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    for (genvar k = 0; k < 12; k++) begin : g_unpack
        assign m[k] = s_tdata[k*DATA_W +: DATA_W];
    end

    for (genvar k = 0; k < 9; k++) begin : g_sq
        logic [DATA_W-1:0] a;
        assign a = m[k][DATA_W-1] ? DATA_W'(-m[k]) : DATA_W'(m[k]);
        always_ff @(posedge aclk) begin
            if (en) begin
                sq_reg[k] <= SQ_W'(a) * SQ_W'(a);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum_reg[0] <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            sum_reg[1] <= sq_reg[3] + sq_reg[4] + sq_reg[5];
            sum_reg[2] <= sq_reg[6] + sq_reg[7] + sq_reg[8];
            sum_reg[3] <= sq_reg[5] + sq_reg[8];
        end
    end

    for (genvar k = 0; k < 4; k++) begin : g_root
        dme_sqrt u_sqrt (
            .aclk     (aclk),
            .en       (en),
            .n_in     (sum_reg[k]),
            .root_out (root[k])
        );
    end

    assign side_in = '{m11: m[0], m12: m[1], m13: m[2], m23: m[5], m33: m[8],
                       m41: m[9], m42: m[10], m43: m[11]};

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= side_in;
            for (int k = 1; k < MDLY_LAT; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_comb begin
        cy[0] = OPND_W'(side_reg[MDLY_LAT-1].m23);
        cx[0] = OPND_W'(side_reg[MDLY_LAT-1].m33);
        cy[1] = -OPND_W'(side_reg[MDLY_LAT-1].m13);
        cx[1] = OPND_W'({1'b0, root[3]});
        cy[2] = OPND_W'(side_reg[MDLY_LAT-1].m12);
        cx[2] = OPND_W'(side_reg[MDLY_LAT-1].m11);
    end

    dme_cordic u_cordic_x (.aclk(aclk), .en(en), .y_in(cy[0]), .x_in(cx[0]), .angle_out(ang_x));
    dme_cordic u_cordic_y (.aclk(aclk), .en(en), .y_in(cy[1]), .x_in(cx[1]), .angle_out(ang_y));
    dme_cordic u_cordic_z (.aclk(aclk), .en(en), .y_in(cy[2]), .x_in(cx[2]), .angle_out(ang_z));

    assign tail_in = '{sx: root[0], sy: root[1], sz: root[2],
                       px: side_reg[MDLY_LAT-1].m41, py: side_reg[MDLY_LAT-1].m42,
                       pz: side_reg[MDLY_LAT-1].m43};

    always_ff @(posedge aclk) begin
        if (en) begin
            tail_reg[0] <= tail_in;
            for (int k = 1; k < CORDIC_LAT; k++) begin
                tail_reg[k] <= tail_reg[k-1];
            end
        end
    end

    assign m_tvalid = vld_reg[TOTAL_LAT-1];
    assign m_tdata  = {{(M_TDATA_W-M_FIELDS_W){1'b0}},
                       tail_reg[CORDIC_LAT-1].pz, tail_reg[CORDIC_LAT-1].py,
                       tail_reg[CORDIC_LAT-1].px, ang_z, ang_y, ang_x,
                       tail_reg[CORDIC_LAT-1].sz, tail_reg[CORDIC_LAT-1].sy,
                       tail_reg[CORDIC_LAT-1].sx};

endmodule

// ----- hw/rtl/dme_checker.sv -----
`include "assert_macros.svh"

module dme_checker import dme_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic [S_TDATA_W-1:0] s_tdata,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    `DME_ASSERT_DIS(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    `DME_ASSERT_DIS(a_ready_free, aclk, aresetn, !m_tvalid |-> s_tready)
    `DME_ASSERT_ALL(a_reset_empty, aclk, !aresetn |=> !m_tvalid)
    `DME_ASSERT_DIS(a_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[M_TDATA_W-1:M_FIELDS_W] == '0)

endmodule

bind decompose_matrix_euler_unit dme_checker u_dme_checker (.*);

// ----- tb/sv/tb_top.sv -----
module tb_top;
    import dme_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    int tx_idle_pct;
    int rx_idle_pct;

    class decomp_scoreboard;
        logic [M_TDATA_W-1:0] pending_q[$];
        int                   errors;

        function new();
            errors = 0;
        endfunction

        static function logic [63:0] mag_squared(longint v);
            longint a;
            a = (v < 0) ? -v : v;
            return a * a;
        endfunction

        static function logic [63:0] root_nearest(logic [63:0] n);
            logic [63:0] res;
            logic [63:0] b;
            res = '0;
            b = 64'd1 << 62;
            while (b > n) b = b >> 2;
            while (b != 0) begin
                if (n >= res + b) begin
                    n = n - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            if (n > res) res = res + 1;
            return res;
        endfunction

        static function longint rot_step_deg(int i);
            case (i)
                0:  return 64'sd193273528320;
                1:  return 64'sd114096026022;
                2:  return 64'sd60285206653;
                3:  return 64'sd30601712202;
                4:  return 64'sd15360239180;
                5:  return 64'sd7687607525;
                6:  return 64'sd3844741810;
                7:  return 64'sd1922488225;
                8:  return 64'sd961258780;
                9:  return 64'sd480631223;
                10: return 64'sd240315841;
                11: return 64'sd120157949;
                12: return 64'sd60078978;
                13: return 64'sd30039489;
                default: return (64'sd246083499208 + (64'sd1 <<< (i - 1))) >>> i;
            endcase
        endfunction

        static function logic [ANGLE_W-1:0] heading_deg(longint y, longint x);
            longint z;
            longint dx;
            longint dy;
            longint r;
            z = 0;
            if (x == 0 && y == 0) return '0;
            if (x < 0) begin
                z = (y >= 0) ? 64'sd773094113280 : -64'sd773094113280;
                x = -x;
                y = -y;
            end
            x = x <<< PRESCALE;
            y = y <<< PRESCALE;
            for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + rot_step_deg(i);
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - rot_step_deg(i);
                end
            end
            r = (z + (64'sd1 <<< (ANGLE_FRAC - FRAC_BITS - 1))) >>> (ANGLE_FRAC - FRAC_BITS);
            return r[ANGLE_W-1:0];
        endfunction

        function void note_matrix(logic [S_TDATA_W-1:0] d);
            longint      m[12];
            logic [63:0] sc[3];
            logic [63:0] len_yz;
            logic [ANGLE_W-1:0] ax, ay, az;
            for (int k = 0; k < 12; k++) m[k] = longint'($signed(d[k*32 +: 32]));
            for (int r = 0; r < 3; r++)
                sc[r] = root_nearest(mag_squared(m[3*r]) + mag_squared(m[3*r+1])
                                     + mag_squared(m[3*r+2]));
            len_yz = root_nearest(mag_squared(m[5]) + mag_squared(m[8]));
            ax = heading_deg(m[5], m[8]);
            ay = heading_deg(-m[2], longint'(len_yz));
            az = heading_deg(m[1], m[0]);
            pending_q.push_back({5'b0, d[383:352], d[351:320], d[319:288], az, ay, ax,
                                 sc[2][31:0], sc[1][31:0], sc[0][31:0]});
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(logic [M_TDATA_W-1:0] got);
            logic [M_TDATA_W-1:0] want;
            int    lsb[9];
            int    wid[9];
            string nm[9];
            logic [31:0] g, w;
            lsb = '{0, 32, 64, 96, 121, 146, 171, 203, 235};
            wid = '{32, 32, 32, 25, 25, 25, 32, 32, 32};
            nm = '{"scale_x", "scale_y", "scale_z", "angle_x", "angle_y", "angle_z",
                   "pos_x", "pos_y", "pos_z"};
            if (pending_q.size() == 0) begin
                report("unexpected transfer", got[31:0], '0);
            end else begin
                want = pending_q.pop_front();
                for (int f = 0; f < 9; f++) begin
                    g = 32'((got >> lsb[f]) & ((64'd1 << wid[f]) - 1));
                    w = 32'((want >> lsb[f]) & ((64'd1 << wid[f]) - 1));
                    if (g !== w) report(nm[f], g, w);
                end
            end
        endtask
    endclass

    decomp_scoreboard sb = new();

    decompose_matrix_euler_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // monitors
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_matrix(s_tdata);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    always @(negedge aclk) begin
        if (!aresetn) m_tready = 1'b0;
        else m_tready = ($urandom_range(99) >= rx_idle_pct);
    end

    task send_matrix(logic [S_TDATA_W-1:0] d);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            s_tdata  = {$urandom, $urandom, $urandom, $urandom};
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = d;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task send_rows(logic [31:0] a, logic [31:0] b, logic [31:0] c, logic [31:0] e,
                   logic [31:0] f, logic [31:0] g, logic [31:0] h, logic [31:0] i,
                   logic [31:0] j, logic [31:0] k, logic [31:0] l, logic [31:0] n);
        send_matrix({n, l, k, j, i, h, g, f, e, c, b, a});
    endtask

    task drain;
        s_tvalid = 1'b0;
        while (sb.pending_q.size() != 0) @(negedge aclk);
    endtask

    function logic [31:0] pick_elem(int kind);
        case (kind)
            0: return $urandom;
            1: return $unsigned(32'($signed($urandom_range(524288)) - 262144));
            default: begin
                case ($urandom_range(5))
                    0: return 32'h0;
                    1: return 32'h7fffffff;
                    2: return 32'h80000000;
                    3: return 32'h00010000;
                    4: return 32'hffff0000;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    task send_random(int count);
        logic [S_TDATA_W-1:0] d;
        int kind;
        for (int n = 0; n < count; n++) begin
            kind = $urandom_range(2);
            for (int k = 0; k < 12; k++) d[k*32 +: 32] = pick_elem(kind);
            send_matrix(d);
        end
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed corners
        send_rows(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        send_rows(32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 32'h10000, 1, 2, 3);
        send_matrix({12{32'h7fffffff}});
        send_matrix({12{32'h80000000}});
        send_rows(32'hffff0000, 0, 0, 0, 0, 0, 0, 0, 32'hffff0000,
                  32'h7fffffff, 32'h80000000, 32'hffffffff);
        send_rows(32'hffff0000, 32'hffff0000, 32'h10000, 0, 0, 32'hffff0000,
                  0, 0, 32'hffff0000, 0, 0, 0);
        send_rows(32'h10000, 32'h10000, 32'h80000000, 0, 0, 32'h10000,
                  0, 0, 0, 0, 0, 0);
        send_rows(0, 32'h7fffffff, 32'h7fffffff, 0, 32'h80000000, 32'h80000000,
                  0, 0, 32'h80000000, 0, 0, 0);
        send_rows(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                  32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        send_rows(32'hddb4, 32'h8000, 32'hffff8000, 0, 32'hddb4, 32'hddb4,
                  32'h1, 32'hffffffff, 32'h1, 32'h123456, 32'hfedcba98, 0);
        send_rows(1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0);
        send_rows(32'hffffffff, 0, 0, 0, 0, 32'hffffffff, 0, 0, 0, 0, 0, 0);

        tx_idle_pct = 13;
        rx_idle_pct = 72;
        send_random(310);
        // full pause until the pipeline is empty
        drain();
        tx_idle_pct = 72;
        rx_idle_pct = 13;
        send_random(310);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        send_random(310);

        drain();
        repeat (70) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+hw/rtl
hw/rtl/dme_pkg.sv
hw/rtl/dme_sqrt.sv
hw/rtl/dme_cordic.sv
hw/rtl/decompose_matrix_euler_unit.sv
hw/rtl/dme_checker.sv
tb/sv/tb_top.sv
